@@ design/frustum_cull_test_core_macros.svh @@
// Assertion macros for the frustum cull test core.
`ifndef FRUSTUM_CULL_TEST_CORE_MACROS_SVH
`define FRUSTUM_CULL_TEST_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on clk, off during reset.
`define FCT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frustum cull check failed");
// Next-cycle implication, checked on clk, off during reset.
`define FCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frustum cull check failed");
`else
`define FCT_ASSERT_NOW(label, ante, cons)
`define FCT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/fct_pkg.sv @@
// Types and constants shared by the frustum cull test core.
`timescale 1ns / 1ps
`default_nettype none
package fct_pkg;

	localparam int NUM_PLANES = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int COORD_W    = 16;
	localparam int RAD_W      = 15;
	localparam int OP_W       = 2;
	localparam int PROD_W     = 2 * COORD_W;
	// three products plus d plus radius, with margin
	localparam int SUM_W      = PROD_W + 3;

	localparam logic [OP_W-1:0] OP_POINT  = 2'd0;
	localparam logic [OP_W-1:0] OP_BOX    = 2'd1;
	localparam logic [OP_W-1:0] OP_TWO_PT = 2'd2;
	localparam logic [OP_W-1:0] OP_SPHERE = 2'd3;

	// Register layout: d in the top field, a in the bottom one.
	typedef struct packed {
		logic signed [COORD_W-1:0] d;
		logic signed [COORD_W-1:0] c;
		logic signed [COORD_W-1:0] b;
		logic signed [COORD_W-1:0] a;
	} plane_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	// Per-plane verdicts handed from a lane to the result logic.
	typedef struct packed {
		logic pt_first;
		logic pt_second;
		logic box;
		logic sphere;
	} plane_pass_t;

endpackage
`default_nettype wire

@@ design/fct_if.sv @@
// Request and response channel interfaces of the frustum cull test core.
`timescale 1ns / 1ps
`default_nettype none
interface fct_req_if;
	import fct_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic signed [COORD_W-1:0] x_first;
	logic signed [COORD_W-1:0] y_first;
	logic signed [COORD_W-1:0] z_first;
	logic signed [COORD_W-1:0] x_second;
	logic signed [COORD_W-1:0] y_second;
	logic signed [COORD_W-1:0] z_second;
	logic [RAD_W-1:0]          radius;

	modport source (output valid, op, x_first, y_first, z_first,
		x_second, y_second, z_second, radius, input ready);
	modport sink (input valid, op, x_first, y_first, z_first,
		x_second, y_second, z_second, radius, output ready);
endinterface

interface fct_rsp_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface
`default_nettype wire

@@ design/fct_plane_regs.sv @@
// Plane configuration registers of the frustum cull test core.
`timescale 1ns / 1ps
`default_nettype none
module fct_plane_regs
	import fct_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output plane_t                     planes [NUM_PLANES]
);

	plane_t plane_q [NUM_PLANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_we) begin
			// indices past the last plane fall through and are dropped
			for (int i = 0; i < NUM_PLANES; i++) begin
				if (cfg_idx == CFG_IDX_W'(i)) begin
					plane_q[i] <= plane_t'(cfg_wdata);
				end
			end
		end
	end

	assign planes = plane_q;

endmodule
`default_nettype wire

@@ design/fct_plane_lane.sv @@
// One plane lane: product register and distance tests for a single plane.
`timescale 1ns / 1ps
`default_nettype none
module fct_plane_lane
	import fct_pkg::*;
#(
	parameter int COEFF_FRAC_BITS = 14
) (
	input  wire logic             clk,
	input  wire logic             load,
	input  plane_t                plane,
	input  point_t                pt_first,
	input  point_t                pt_second,
	input  wire logic [RAD_W-1:0] radius,
	output plane_pass_t           pass
);

	logic signed [PROD_W-1:0] af_s2, bf_s2, cf_s2;
	logic signed [PROD_W-1:0] as_s2, bs_s2, cs_s2;

	always_ff @(posedge clk) begin
		if (load) begin
			af_s2 <= PROD_W'(plane.a) * PROD_W'(pt_first.x);
			bf_s2 <= PROD_W'(plane.b) * PROD_W'(pt_first.y);
			cf_s2 <= PROD_W'(plane.c) * PROD_W'(pt_first.z);
			as_s2 <= PROD_W'(plane.a) * PROD_W'(pt_second.x);
			bs_s2 <= PROD_W'(plane.b) * PROD_W'(pt_second.y);
			cs_s2 <= PROD_W'(plane.c) * PROD_W'(pt_second.z);
		end
	end

	logic signed [SUM_W-1:0] sum_f, sum_s, sum_max;
	logic signed [SUM_W-1:0] dist_f, dist_s, dist_max, d_ext, rad_ext, dist_sph;
	logic signed [PROD_W-1:0] max_a, max_b, max_c;

	always_comb begin
		// best box corner per axis: larger product wins (floor shift is monotonic)
		max_a = (af_s2 > as_s2) ? af_s2 : as_s2;
		max_b = (bf_s2 > bs_s2) ? bf_s2 : bs_s2;
		max_c = (cf_s2 > cs_s2) ? cf_s2 : cs_s2;

		sum_f   = SUM_W'(af_s2) + SUM_W'(bf_s2) + SUM_W'(cf_s2);
		sum_s   = SUM_W'(as_s2) + SUM_W'(bs_s2) + SUM_W'(cs_s2);
		sum_max = SUM_W'(max_a) + SUM_W'(max_b) + SUM_W'(max_c);

		d_ext   = SUM_W'(plane.d);
		rad_ext = signed'(SUM_W'({1'b0, radius}));

		// arithmetic shift floors toward minus infinity
		dist_f   = (sum_f >>> COEFF_FRAC_BITS) + d_ext;
		dist_s   = (sum_s >>> COEFF_FRAC_BITS) + d_ext;
		dist_max = (sum_max >>> COEFF_FRAC_BITS) + d_ext;
		dist_sph = dist_f + rad_ext;

		pass.pt_first  = ~dist_f[SUM_W-1];
		pass.pt_second = ~dist_s[SUM_W-1];
		pass.box       = ~dist_max[SUM_W-1];
		pass.sphere    = ~dist_sph[SUM_W-1];
	end

endmodule
`default_nettype wire

@@ design/frustum_cull_test_core.sv @@
// Top level of the six-plane view-frustum cull test core.
`timescale 1ns / 1ps
`default_nettype none
`include "frustum_cull_test_core_macros.svh"
// Tests a point, a box, a pair of points or a sphere against six planes held
// in registers (right, left, bottom, top, far, near at indices 0 to 5, each
// d:c:b:a from the top 16 bits down, a/b/c in Q1.COEFF_FRAC_BITS) and returns
// one visible bit per request. Throughput is one request per cycle while rsp
// takes results; a stalled rsp holds the pipe. The path has three registers:
// an input register, a register of the 36 16x16 plane products (six lanes,
// first and second point on each axis), and the result register after the
// add/shift/compare logic. Box mode uses the per-axis larger product, i.e.
// the corner farthest inside each plane. Each stage holds when the one after
// it is full and stalled, so bubbles close up and a request is still taken
// while a result waits. The user must rewrite planes only when the pipe is
// empty; the core does not enforce it. Writes above index 5 are dropped.
// After reset all planes are zero and everything is visible.
module frustum_cull_test_core
	import fct_pkg::*;
#(
	parameter int COEFF_FRAC_BITS = 14
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	fct_req_if.sink                    req,
	fct_rsp_if.source                  rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	plane_t planes [NUM_PLANES];

	fct_plane_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.planes    (planes)
	);

	// stage enables, drained from the output side
	logic en_out, en_s2, en_s1;
	logic v_s1, v_s2, v_out_q;

	assign en_out    = !v_out_q || rsp.ready;
	assign en_s2     = !v_s2 || en_out;
	assign en_s1     = !v_s1 || en_s2;
	assign req.ready = en_s1;

	// stage 1: request register
	logic [OP_W-1:0]  op_s1;
	point_t           first_s1, second_s1;
	logic [RAD_W-1:0] radius_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req.valid) begin
			op_s1     <= req.op;
			first_s1  <= '{x: req.x_first, y: req.y_first, z: req.z_first};
			second_s1 <= '{x: req.x_second, y: req.y_second, z: req.z_second};
			radius_s1 <= req.radius;
		end
	end

	// stage 2: products live inside the lanes
	logic [OP_W-1:0]  op_s2;
	logic [RAD_W-1:0] radius_s2;
	logic             load_s2;

	assign load_s2 = en_s2 && v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			op_s2     <= op_s1;
			radius_s2 <= radius_s1;
		end
	end

	plane_pass_t pass [NUM_PLANES];

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
		fct_plane_lane #(
			.COEFF_FRAC_BITS (COEFF_FRAC_BITS)
		) u_lane (
			.clk       (clk),
			.load      (load_s2),
			.plane     (planes[p]),
			.pt_first  (first_s1),
			.pt_second (second_s1),
			.radius    (radius_s2),
			.pass      (pass[p])
		);
	end

	// combine the six lanes per mode
	logic all_first, all_second, all_box, all_sphere, visible_d;

	always_comb begin
		all_first  = 1'b1;
		all_second = 1'b1;
		all_box    = 1'b1;
		all_sphere = 1'b1;
		for (int p = 0; p < NUM_PLANES; p++) begin
			all_first  = all_first & pass[p].pt_first;
			all_second = all_second & pass[p].pt_second;
			all_box    = all_box & pass[p].box;
			all_sphere = all_sphere & pass[p].sphere;
		end
		case (op_s2)
			OP_POINT:  visible_d = all_first;
			OP_BOX:    visible_d = all_box;
			OP_TWO_PT: visible_d = all_first | all_second;
			OP_SPHERE: visible_d = all_sphere;
			default:   visible_d = all_first;
		endcase
	end

	// result register
	logic visible_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en_out) begin
			v_out_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			visible_q <= visible_d;
		end
	end

	assign rsp.valid   = v_out_q;
	assign rsp.visible = visible_q;

	// a blocked request stage keeps its contents
	`FCT_ASSERT_NEXT(a_s1_hold, v_s1 && !en_s2, v_s1 && $stable(op_s1))
	// a product stage that drains always lands in the result register
	`FCT_ASSERT_NEXT(a_s2_to_out, v_s2 && en_out, v_out_q)
	// requests are refused only when every stage is full
	`FCT_ASSERT_NOW(a_ready_full, !req.ready, v_s1 && v_s2 && v_out_q)

endmodule
`default_nettype wire
